### hdl/foas_pkg.sv
// Package for the fuzzy obstacle-avoidance speed controller.
// Holds field widths, trapezoid break points, ramp reciprocals, codes and shared types.
// No dependencies; every other file in hdl imports it.
`timescale 1ns / 1ps
`default_nettype none

package foas_pkg;

    // Field widths.
    localparam int RANGE_W    = 14;
    localparam int SPEED_W    = 10;
    localparam int LEVELS_W   = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Memberships are Q1.15 with one at 32768, so they need 16 bits.
    localparam int Q_W   = 16;
    localparam int OFS_W = 8;
    localparam int NUM_RULES = 9;
    // Sum of nine strengths and sum of nine strength times speed products.
    localparam int DEN_W  = 19;
    localparam int PROD_W = Q_W + SPEED_W;
    localparam int NUM_W  = 29;

    localparam logic [Q_W-1:0] Q_ONE = 16'h8000;

    // Input clamp and trapezoid break points in millimeters.
    localparam logic [RANGE_W-1:0] RANGE_MAX      = 14'd10000;
    localparam logic [RANGE_W-1:0] CLOSE_PLATEAU  = 14'd100;
    localparam logic [RANGE_W-1:0] CLOSE_FOOT     = 14'd350;
    localparam logic [RANGE_W-1:0] MED_FOOT_LO    = 14'd100;
    localparam logic [RANGE_W-1:0] MED_SHOULDER_LO = 14'd325;
    localparam logic [RANGE_W-1:0] MED_SHOULDER_HI = 14'd375;
    localparam logic [RANGE_W-1:0] MED_FOOT_HI    = 14'd600;
    localparam logic [RANGE_W-1:0] FAR_FOOT       = 14'd350;
    localparam logic [RANGE_W-1:0] FAR_SHOULDER   = 14'd600;

    // Ramp value floor(n * 32768 / D) for n < D is computed as
    // (n * ceil(2^31 / D)) >> 16, which is exact for every 8-bit n.
    localparam int RAMP_DIV_OUTER  = 250;
    localparam int RAMP_DIV_MEDIUM = 225;
    localparam int RECIP_SHIFT     = 31;
    localparam int RECIP_W         = 24;
    localparam int RAMP_SHIFT      = OFS_W + RECIP_W - Q_W;
    localparam logic [RECIP_W-1:0] RECIP_OUTER =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(RAMP_DIV_OUTER) - 64'd1) / 64'(RAMP_DIV_OUTER));
    localparam logic [RECIP_W-1:0] RECIP_MEDIUM =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(RAMP_DIV_MEDIUM) - 64'd1) / 64'(RAMP_DIV_MEDIUM));

    // Membership class codes produced by the front end.
    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_RAMP = 2'd2;

    // Output level codes; every other code means fast.
    localparam logic [1:0] LEVEL_SLOW   = 2'd0;
    localparam logic [1:0] LEVEL_MODEST = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODEST_SPEED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SPEED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LEVELS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LEVELS = 3'd4;

    // Configuration reset values.
    localparam logic [SPEED_W-1:0]  SLOW_SPEED_RST   = 10'd0;
    localparam logic [SPEED_W-1:0]  MODEST_SPEED_RST = 10'd150;
    localparam logic [SPEED_W-1:0]  FAST_SPEED_RST   = 10'd300;
    localparam logic [LEVELS_W-1:0] LEFT_LEVELS_RST  = 18'd65536;
    localparam logic [LEVELS_W-1:0] RIGHT_LEVELS_RST = 18'd91562;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef logic [Q_W-1:0] memb_t;

    // One membership as classified by the front end.
    typedef struct packed {
        logic [1:0]       kind;
        logic [OFS_W-1:0] ofs;
    } memb_cls_t;

    // Close, medium and far, index 0 to 2.
    typedef memb_cls_t [2:0] memb_set_t;

    // One classified item as it travels through the queue.
    typedef struct packed {
        memb_set_t lf;
        memb_set_t rf;
    } item_cls_t;

    // Configuration registers as seen by the back end.
    typedef struct packed {
        logic [SPEED_W-1:0]  slow_speed;
        logic [SPEED_W-1:0]  modest_speed;
        logic [SPEED_W-1:0]  fast_speed;
        logic [LEVELS_W-1:0] left_levels;
        logic [LEVELS_W-1:0] right_levels;
    } cfg_t;

endpackage

`default_nettype wire

### hdl/foas_front.sv
// Front end: accepts an item, clamps both ranges and classifies each membership.
// Each membership becomes zero, one or a ramp with an 8-bit offset.
// Depends on foas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module foas_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [foas_pkg::RANGE_W-1:0]  left_front_range,
    input  wire logic [foas_pkg::RANGE_W-1:0]  right_front_range,
    output logic                               push,
    output foas_pkg::item_cls_t                push_data,
    input  wire logic                          queue_full
);
    import foas_pkg::*;

    // Classify one clamped distance against the three trapezoids.
    function automatic memb_set_t classify(input logic [RANGE_W-1:0] raw);
        logic [RANGE_W-1:0] x;
        logic [RANGE_W-1:0] diff;
        memb_set_t          m;
        x = (raw > RANGE_MAX) ? RANGE_MAX : raw;
        m = '0;
        // Close: plateau up to its shoulder, then a falling ramp.
        if (x <= CLOSE_PLATEAU) begin
            m[0].kind = KIND_ONE;
        end else if (x < CLOSE_FOOT) begin
            diff      = CLOSE_FOOT - x;
            m[0].kind = KIND_RAMP;
            m[0].ofs  = diff[OFS_W-1:0];
        end else begin
            m[0].kind = KIND_ZERO;
        end
        // Medium: rising ramp, plateau, falling ramp.
        if (x < MED_FOOT_LO) begin
            m[1].kind = KIND_ZERO;
        end else if (x < MED_SHOULDER_LO) begin
            diff      = x - MED_FOOT_LO;
            m[1].kind = KIND_RAMP;
            m[1].ofs  = diff[OFS_W-1:0];
        end else if (x <= MED_SHOULDER_HI) begin
            m[1].kind = KIND_ONE;
        end else if (x < MED_FOOT_HI) begin
            diff      = MED_FOOT_HI - x;
            m[1].kind = KIND_RAMP;
            m[1].ofs  = diff[OFS_W-1:0];
        end else begin
            m[1].kind = KIND_ZERO;
        end
        // Far: rising ramp, then plateau up to the clamp.
        if (x < FAR_FOOT) begin
            m[2].kind = KIND_ZERO;
        end else if (x < FAR_SHOULDER) begin
            diff      = x - FAR_FOOT;
            m[2].kind = KIND_RAMP;
            m[2].ofs  = diff[OFS_W-1:0];
        end else begin
            m[2].kind = KIND_ONE;
        end
        return m;
    endfunction

    logic      valid_reg;
    item_cls_t item_reg;
    item_cls_t item_next;
    logic      accept;

    // The register holds one classified item until the queue takes it.
    assign in_stall  = valid_reg && queue_full;
    assign accept    = in_valid && !in_stall;
    assign push      = valid_reg && !queue_full;
    assign push_data = item_reg;

    always_comb
    begin
        item_next.lf = classify(left_front_range);
        item_next.rf = classify(right_front_range);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

### hdl/foas_queue.sv
// Short queue of classified items between the front end and the back end.
// Register-based ring buffer with an occupancy count.
// Depends on foas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module foas_queue #(
    parameter int DEPTH = foas_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire foas_pkg::item_cls_t  push_data,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      pop_valid,
    output foas_pkg::item_cls_t       pop_data
);
    import foas_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_cls_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push_en;
    logic            pop_en;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign push_en   = push && !full;
    assign pop_en    = pop && pop_valid;
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_en && !pop_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_en && !push_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/foas_div.sv
// Pipelined restoring divider for both wheels, one quotient bit per stage.
// Shares the denominator; a zero denominator forces a zero quotient.
// Depends on foas_pkg.
`timescale 1ns / 1ps
`default_nettype none

module foas_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [foas_pkg::NUM_W-1:0]    num_l,
    input  wire logic [foas_pkg::NUM_W-1:0]    num_r,
    input  wire logic [foas_pkg::DEN_W-1:0]    den,
    input  wire logic                          den_zero,
    output logic                               out_valid,
    output logic [foas_pkg::SPEED_W-1:0]       quot_l,
    output logic [foas_pkg::SPEED_W-1:0]       quot_r
);
    import foas_pkg::*;

    localparam int STAGES = SPEED_W;

    logic               valid_reg [STAGES];
    logic [NUM_W-1:0]   rem_l_reg [STAGES];
    logic [NUM_W-1:0]   rem_r_reg [STAGES];
    logic [DEN_W-1:0]   den_reg   [STAGES];
    logic               zero_reg  [STAGES];
    logic [SPEED_W-1:0] quot_l_reg [STAGES];
    logic [SPEED_W-1:0] quot_r_reg [STAGES];

    // The weighted average never exceeds the largest speed, so the quotient
    // fits in SPEED_W bits and the first stage starts at the top bit.
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        localparam int BIT = STAGES - 1 - s;

        logic               valid_in;
        logic [NUM_W-1:0]   rem_l_in;
        logic [NUM_W-1:0]   rem_r_in;
        logic [DEN_W-1:0]   den_in;
        logic               zero_in;
        logic [SPEED_W-1:0] quot_l_in;
        logic [SPEED_W-1:0] quot_r_in;
        logic [NUM_W-1:0]   den_shift;
        logic               take_l;
        logic               take_r;
        logic [NUM_W-1:0]   rem_l_next;
        logic [NUM_W-1:0]   rem_r_next;
        logic [SPEED_W-1:0] quot_l_next;
        logic [SPEED_W-1:0] quot_r_next;

        if (s == 0)
        begin : g_first
            assign valid_in  = in_valid;
            assign rem_l_in  = num_l;
            assign rem_r_in  = num_r;
            assign den_in    = den;
            assign zero_in   = den_zero;
            assign quot_l_in = '0;
            assign quot_r_in = '0;
        end
        else
        begin : g_next
            assign valid_in  = valid_reg[s-1];
            assign rem_l_in  = rem_l_reg[s-1];
            assign rem_r_in  = rem_r_reg[s-1];
            assign den_in    = den_reg[s-1];
            assign zero_in   = zero_reg[s-1];
            assign quot_l_in = quot_l_reg[s-1];
            assign quot_r_in = quot_r_reg[s-1];
        end

        // Trial subtraction of the shifted denominator.
        always_comb
        begin
            den_shift   = NUM_W'(den_in) << BIT;
            take_l      = (rem_l_in >= den_shift) && !zero_in;
            take_r      = (rem_r_in >= den_shift) && !zero_in;
            rem_l_next  = take_l ? rem_l_in - den_shift : rem_l_in;
            rem_r_next  = take_r ? rem_r_in - den_shift : rem_r_in;
            quot_l_next = quot_l_in;
            quot_r_next = quot_r_in;
            quot_l_next[BIT] = take_l;
            quot_r_next[BIT] = take_r;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_l_reg[s]  <= rem_l_next;
                rem_r_reg[s]  <= rem_r_next;
                den_reg[s]    <= den_in;
                zero_reg[s]   <= zero_in;
                quot_l_reg[s] <= quot_l_next;
                quot_r_reg[s] <= quot_r_next;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quot_l    = quot_l_reg[STAGES-1];
    assign quot_r    = quot_r_reg[STAGES-1];

endmodule

`default_nettype wire

### hdl/foas_back.sv
// Back end: ramp evaluation, rule strengths, weighted sums and division.
// The whole pipeline moves together unless a finished item is held at the output.
// Depends on foas_pkg and foas_div.
`timescale 1ns / 1ps
`default_nettype none

module foas_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire foas_pkg::cfg_t                cfg,
    input  wire logic                          q_valid,
    input  wire foas_pkg::item_cls_t           q_data,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [foas_pkg::SPEED_W-1:0]       left_speed,
    output logic [foas_pkg::SPEED_W-1:0]       right_speed
);
    import foas_pkg::*;

    // Speed value for a two-bit level code.
    function automatic logic [SPEED_W-1:0] level_speed(input logic [1:0] code, input cfg_t c);
        logic [SPEED_W-1:0] sp;
        case (code)
            LEVEL_SLOW:   sp = c.slow_speed;
            LEVEL_MODEST: sp = c.modest_speed;
            default:      sp = c.fast_speed;
        endcase
        return sp;
    endfunction

    // Membership value from its class; the ramp uses a reciprocal multiply.
    function automatic memb_t memb_value(input memb_cls_t m, input logic [RECIP_W-1:0] recip);
        logic [OFS_W+RECIP_W-1:0] prod;
        memb_t                    v;
        prod = (OFS_W + RECIP_W)'(m.ofs) * (OFS_W + RECIP_W)'(recip);
        case (m.kind)
            KIND_ONE:  v = Q_ONE;
            KIND_RAMP: v = prod[RAMP_SHIFT +: Q_W];
            default:   v = '0;
        endcase
        return v;
    endfunction

    logic adv;

    logic        p1_valid_reg;
    memb_t       lf_memb_reg [3];
    memb_t       rf_memb_reg [3];
    memb_t       lf_memb_next [3];
    memb_t       rf_memb_next [3];

    logic        p2_valid_reg;
    memb_t       w_reg  [NUM_RULES];
    memb_t       w_next [NUM_RULES];

    logic              p3_valid_reg;
    logic [PROD_W-1:0] prod_l_reg  [NUM_RULES];
    logic [PROD_W-1:0] prod_r_reg  [NUM_RULES];
    logic [PROD_W-1:0] prod_l_next [NUM_RULES];
    logic [PROD_W-1:0] prod_r_next [NUM_RULES];
    logic [DEN_W-1:0]  den3_reg;
    logic [DEN_W-1:0]  den3_next;

    logic              p4_valid_reg;
    logic [NUM_W-1:0]  num_l_reg;
    logic [NUM_W-1:0]  num_r_reg;
    logic [NUM_W-1:0]  num_l_next;
    logic [NUM_W-1:0]  num_r_next;
    logic [DEN_W-1:0]  den4_reg;
    logic              zero4_reg;

    // Everything advances unless the output holds an item that is not taken.
    assign adv   = !(out_valid && out_stall);
    assign q_pop = adv && q_valid;

    // Stage 1: membership values.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lf_memb_next[i] = memb_value(q_data.lf[i], (i == 1) ? RECIP_MEDIUM : RECIP_OUTER);
            rf_memb_next[i] = memb_value(q_data.rf[i], (i == 1) ? RECIP_MEDIUM : RECIP_OUTER);
        end
    end

    // Stage 2: rule strengths as the minimum of each membership pair.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                w_next[3*i+j] = (lf_memb_reg[i] < rf_memb_reg[j]) ?
                                lf_memb_reg[i] : rf_memb_reg[j];
            end
        end
    end

    // Stage 3: strength times selected speed per rule, and total strength.
    always_comb
    begin
        den3_next = '0;
        for (int k = 0; k < NUM_RULES; k++)
        begin
            prod_l_next[k] = PROD_W'(w_reg[k]) *
                             PROD_W'(level_speed(cfg.left_levels[2*k +: 2], cfg));
            prod_r_next[k] = PROD_W'(w_reg[k]) *
                             PROD_W'(level_speed(cfg.right_levels[2*k +: 2], cfg));
            den3_next      = den3_next + DEN_W'(w_reg[k]);
        end
    end

    // Stage 4: weighted sums for both wheels.
    always_comb
    begin
        num_l_next = '0;
        num_r_next = '0;
        for (int k = 0; k < NUM_RULES; k++)
        begin
            num_l_next = num_l_next + NUM_W'(prod_l_reg[k]);
            num_r_next = num_r_next + NUM_W'(prod_r_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= q_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lf_memb_reg <= lf_memb_next;
            rf_memb_reg <= rf_memb_next;
            w_reg       <= w_next;
            prod_l_reg  <= prod_l_next;
            prod_r_reg  <= prod_r_next;
            den3_reg    <= den3_next;
            num_l_reg   <= num_l_next;
            num_r_reg   <= num_r_next;
            den4_reg    <= den3_reg;
            zero4_reg   <= (den3_reg == '0);
        end
    end

    // Stages 5 onward: quotient bits, last stage is the output register.
    foas_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p4_valid_reg),
        .num_l     (num_l_reg),
        .num_r     (num_r_reg),
        .den       (den4_reg),
        .den_zero  (zero4_reg),
        .out_valid (out_valid),
        .quot_l    (left_speed),
        .quot_r    (right_speed)
    );

endmodule

`default_nettype wire

### hdl/fuzzy_obstacle_avoid_speed.sv
// Fuzzy obstacle-avoidance speed controller, top level.
// An accepted item passes through the front register, the queue, four back stages and
// ten divider stages, the last of which drives output valid. Throughput is one item
// per cycle unless the output is held; the divider sets the depth.
// Reset clears all valid flags and queue pointers and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_obstacle_avoid_speed #(
    parameter int QUEUE_DEPTH = foas_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [foas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [foas_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [foas_pkg::RANGE_W-1:0]     left_front_range,
    input  wire logic [foas_pkg::RANGE_W-1:0]     right_front_range,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [foas_pkg::SPEED_W-1:0]          left_speed,
    output logic [foas_pkg::SPEED_W-1:0]          right_speed
);
    import foas_pkg::*;

    cfg_t      cfg_reg;
    logic      front_push;
    item_cls_t front_data;
    logic      queue_full;
    logic      queue_pop;
    logic      queue_valid;
    item_cls_t queue_data;

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_speed   <= SLOW_SPEED_RST;
            cfg_reg.modest_speed <= MODEST_SPEED_RST;
            cfg_reg.fast_speed   <= FAST_SPEED_RST;
            cfg_reg.left_levels  <= LEFT_LEVELS_RST;
            cfg_reg.right_levels <= RIGHT_LEVELS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SLOW_SPEED:   cfg_reg.slow_speed   <= cfg_data[SPEED_W-1:0];
                CFG_MODEST_SPEED: cfg_reg.modest_speed <= cfg_data[SPEED_W-1:0];
                CFG_FAST_SPEED:   cfg_reg.fast_speed   <= cfg_data[SPEED_W-1:0];
                CFG_LEFT_LEVELS:  cfg_reg.left_levels  <= cfg_data[LEVELS_W-1:0];
                CFG_RIGHT_LEVELS: cfg_reg.right_levels <= cfg_data[LEVELS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Front end: accept and classify.
    foas_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .left_front_range  (left_front_range),
        .right_front_range (right_front_range),
        .push              (front_push),
        .push_data         (front_data),
        .queue_full        (queue_full)
    );

    // Queue between front and back.
    foas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_data),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_valid (queue_valid),
        .pop_data  (queue_data)
    );

    // Back end: evaluate rules and defuzzify.
    foas_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (queue_valid),
        .q_data      (queue_data),
        .q_pop       (queue_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_speed  (left_speed),
        .right_speed (right_speed)
    );

    // Bounds of the configured speed levels, for checking the averages.
    logic [SPEED_W-1:0] spd_min;
    logic [SPEED_W-1:0] spd_max;

    always_comb
    begin
        spd_min = cfg_reg.slow_speed;
        spd_max = cfg_reg.slow_speed;
        if (cfg_reg.modest_speed < spd_min)
        begin
            spd_min = cfg_reg.modest_speed;
        end
        if (cfg_reg.fast_speed < spd_min)
        begin
            spd_min = cfg_reg.fast_speed;
        end
        if (cfg_reg.modest_speed > spd_max)
        begin
            spd_max = cfg_reg.modest_speed;
        end
        if (cfg_reg.fast_speed > spd_max)
        begin
            spd_max = cfg_reg.fast_speed;
        end
    end

    // A weighted average of the level speeds stays within their range.
    a_left_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_speed >= spd_min && left_speed <= spd_max))
        else $error("left speed outside the configured speed range");

    a_right_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (right_speed >= spd_min && right_speed <= spd_max))
        else $error("right speed outside the configured speed range");

    // The front end only stalls while the queue is full.
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> queue_full)
        else $error("input stalled while the queue had room");

    // A held output keeps the queue from draining into the back end.
    a_hold_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !queue_pop)
        else $error("queue popped while the output is held");

endmodule

`default_nettype wire
